// File: sv/affra_pkg.sv
// Shared types and constants of the aligned first-fit region allocator.
package affra_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [48:0] SPACE_SIZE = 49'h1_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic        op;
        logic [49:0] size;
        logic [47:0] fixed_base;
        logic [2:0]  access_bits;
        logic        has_phys;
        logic [51:0] phys_addr;
        logic [48:0] align_mask;
    } req_t;

    typedef struct packed {
        logic [47:0] base;
        logic [48:0] size;
        logic        free_mark;
        logic [2:0]  access_bits;
        logic        phys_valid;
        logic [51:0] phys_frame;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
endpackage

// File: sv/affra_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module affra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/affra_front.sv
// Request intake: queues requests (size rounding and alignment are done in the top level).
module affra_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  affra_pkg::req_t  in_req,
    output logic             q_valid,
    input  logic             q_pop,
    output affra_pkg::req_t  q_req
);
    affra_pkg::req_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push;

    assign in_stall = cnt_reg[1];
    assign push = in_valid && !in_stall;
    assign q_valid = cnt_reg != 2'd0;
    assign q_req = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_req;
        end
    end
endmodule

// File: sv/affra_back.sv
// Table scan and update engine.
module affra_back #(
    parameter int TABLE_DEPTH = affra_pkg::TABLE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  affra_pkg::req_t       q_req,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [47:0]           block_base,
    output logic [48:0]           block_size,
    output logic [1:0]            status
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_W0, S_W1, S_W2, S_OUT
    } state_t;

    state_t          state_reg;
    affra_pkg::req_t req_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg;
    logic [47:0]     bbase_reg;
    logic [48:0]     front_reg, back_reg;
    affra_pkg::entry_t hit_reg;
    logic [47:0]     ob_reg;
    logic [48:0]     os_reg;
    logic [1:0]      st_reg;
    logic            ov_reg;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    affra_pkg::entry_t wdata, rdata, e;

    affra_ram #(.WIDTH(affra_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic        init_reg;
    affra_pkg::entry_t init_e;
    assign init_e = '{base: 48'd0, size: affra_pkg::SPACE_SIZE, free_mark: 1'b1,
                      access_bits: 3'd0, phys_valid: 1'b0, phys_frame: 52'd0};
    assign e = (init_reg && idx_reg == '0) ? init_e : rdata;

    logic [49:0] ab, pad, endr, need;
    logic [49:0] fend;
    logic        fit;
    always_comb
    begin
        ab = ({2'b0, e.base} + {1'b0, req_reg.align_mask}) & ~{1'b0, req_reg.align_mask};
        pad = ab - {2'b0, e.base};
        endr = {2'b0, e.base} + {1'b0, e.size};
        need = req_reg.size + pad;
        fend = {2'b0, req_reg.fixed_base} + req_reg.size;
        if (!req_reg.op)
        begin
            fit = e.free_mark && ({1'b0, e.size} >= need);
        end
        else
        begin
            fit = e.free_mark && (req_reg.fixed_base >= e.base) && (fend < endr);
        end
    end

    assign raddr = idx_reg[AW-1:0];
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign out_valid = ov_reg;
    assign block_base = ob_reg;
    assign block_size = os_reg;
    assign status = st_reg;

    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = hit_reg;
        unique case (state_reg)
            S_W0:
            begin
                we = 1'b1;
                wdata.size = front_reg;
                if (req_reg.op)
                begin
                    wdata.access_bits = 3'd0;
                    wdata.phys_valid = 1'b0;
                    wdata.phys_frame = 52'd0;
                end
            end
            S_W1:
            begin
                we = 1'b1;
                waddr = count_reg[AW-1:0];
                wdata = '{base: bbase_reg, size: req_reg.size[48:0], free_mark: 1'b0,
                          access_bits: req_reg.access_bits,
                          phys_valid: req_reg.has_phys,
                          phys_frame: req_reg.has_phys ? req_reg.phys_addr : 52'd0};
            end
            S_W2:
            begin
                we = 1'b1;
                waddr = AW'(count_reg + CW'(1));
                wdata = '{base: 48'(bbase_reg + req_reg.size[47:0]), size: back_reg,
                          free_mark: 1'b1, access_bits: 3'd0, phys_valid: 1'b0,
                          phys_frame: 52'd0};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg <= '0;
            count_reg <= CW'(1);
            idx_reg <= '0;
            bbase_reg <= '0;
            front_reg <= '0;
            back_reg <= '0;
            hit_reg <= '0;
            ob_reg <= '0;
            os_reg <= '0;
            st_reg <= affra_pkg::ST_OK;
            init_reg <= 1'b1;
            ov_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg <= q_req;
                        idx_reg <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (fit)
                    begin
                        hit_reg <= e;
                        if (!req_reg.op)
                        begin
                            bbase_reg <= ab[47:0];
                            front_reg <= pad[48:0];
                            back_reg <= 49'({1'b0, e.size} - need);
                        end
                        else
                        begin
                            bbase_reg <= req_reg.fixed_base;
                            front_reg <= {1'b0, req_reg.fixed_base - e.base};
                            back_reg <= 49'(endr - fend);
                        end
                        if (32'(count_reg) + 2 > TABLE_DEPTH)
                        begin
                            st_reg <= affra_pkg::ST_FULL;
                            ob_reg <= '0;
                            os_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_W0;
                        end
                    end
                    else if (idx_reg + CW'(1) >= count_reg)
                    begin
                        st_reg <= affra_pkg::ST_NO_FIT;
                        ob_reg <= '0;
                        os_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_READ;
                    end
                end
                S_W0:
                begin
                    if (idx_reg == '0)
                    begin
                        init_reg <= 1'b0;
                    end
                    state_reg <= S_W1;
                end
                S_W1:
                begin
                    state_reg <= S_W2;
                end
                S_W2:
                begin
                    count_reg <= count_reg + CW'(2);
                    st_reg <= affra_pkg::ST_OK;
                    ob_reg <= bbase_reg;
                    os_reg <= req_reg.size[48:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        ov_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: sv/aligned_first_fit_region_allocator_top.sv
// Top level of the aligned first-fit region allocator.
// Usage:
//   Input channel in_valid/in_stall carries one request item: op, req_size,
//   fixed_base, access_bits, has_phys, phys_addr. The top level rounds the
//   size to 4 KiB and picks the alignment; the front stage holds up to two items in a queue.
//   Output channel out_valid/out_stall returns block_base, block_size and
//   status (0 ok, 1 no fit, 2 table full) for each request, in order.
//   Flow: an item waits in the queue, then the back stage reads the table
//   entries one at a time through the single RAM read port (S_READ, then
//   S_CHECK) until the first fit, makes three table writes on success
//   (S_W0, S_W1, S_W2), and presents the result in S_OUT.
//   A request with no fit scans every entry in use.
//   One request is processed at a time; the queue takes new items meanwhile.
//   Reset: the table holds one free region of 256 TiB at base zero; the
//   first entry is supplied by a reset flag, so no clearing pass is needed.
//   While out_stall is high the result holds and the back stage waits; the
//   queue fills and then in_stall rises.
module aligned_first_fit_region_allocator_top #(
    parameter int TABLE_DEPTH = affra_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [48:0] req_size,
    input  logic [47:0] fixed_base,
    input  logic [2:0]  access_bits,
    input  logic        has_phys,
    input  logic [51:0] phys_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [47:0] block_base,
    output logic [48:0] block_size,
    output logic [1:0]  status
);
    affra_pkg::req_t in_req, q_req;
    logic q_valid, q_pop;
    logic [49:0] rsize;

    always_comb
    begin
        rsize = ({1'b0, req_size} + 50'hFFF) & ~50'hFFF;
        in_req.op = op;
        in_req.size = rsize;
        in_req.fixed_base = fixed_base;
        in_req.access_bits = access_bits;
        in_req.has_phys = has_phys;
        in_req.phys_addr = phys_addr;
        if (rsize >= 50'h4000_0000)
        begin
            in_req.align_mask = 49'h3FFF_FFFF;
        end
        else if (rsize >= 50'h20_0000)
        begin
            in_req.align_mask = 49'h1F_FFFF;
        end
        else
        begin
            in_req.align_mask = 49'hFFF;
        end
    end

    affra_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    affra_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .out_valid(out_valid), .out_stall(out_stall), .block_base(block_base),
        .block_size(block_size), .status(status)
    );
endmodule
